[src/sbtp_pkg.sv]
// Shared types, sizes and constants of the sine basis tensor product block.
package sbtp_pkg;

  localparam int DIMS          = 2;
  localparam int BASIS_PER_DIM = 4;
  localparam int NREG          = 4;
  localparam int MAX_OUT       = 64;

  localparam int COORD_W = 24;
  localparam int HW_W    = 20;
  localparam int SINE_W  = 18;
  localparam int VALUE_W = 32;
  localparam int INDEX_W = 6;
  localparam int CFG_IDX_W = 2;

  localparam int DIM_W      = (DIMS > 1) ? $clog2(DIMS) : 1;
  localparam int J_W        = $clog2(BASIS_PER_DIM);
  localparam int SINE_DEPTH = DIMS * BASIS_PER_DIM;
  localparam int SINE_AW    = $clog2(SINE_DEPTH);

  function automatic int calc_total();
    int t;
    t = 1;
    for (int d = 0; d < DIMS; d++) begin
      if (t <= MAX_OUT) t = t * BASIS_PER_DIM;
    end
    if (t > MAX_OUT) t = MAX_OUT;
    return t;
  endfunction

  localparam int TOTAL = calc_total();

  // Register indexes of the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_HALF_WIDTH_DIM0 = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HALF_WIDTH_DIM1 = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HALF_WIDTH_DIM2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_HALF_WIDTH_DIM3 = 2'd3;

  localparam logic [HW_W-1:0] HW_RESET = 20'd262144;

  // Odd sine polynomial in Q30, highest order first in the Horner chain.
  localparam logic [30:0] C1 = 31'd1686629713;
  localparam logic [30:0] C3 = 31'd693598668;
  localparam logic [30:0] C5 = 31'd85569306;
  localparam logic [30:0] C7 = 31'd5026995;
  localparam logic [30:0] C9 = 31'd172272;

  typedef struct packed {
    logic [COORD_W-1:0] coord;
    logic               last;
    logic [DIM_W-1:0]   dim;
  } entry_t;

  typedef logic [NREG-1:0][HW_W-1:0] widths_t;

endpackage

[src/sbtp_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module sbtp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

[src/sbtp_front.sv]
// Front end: accepts coordinate beats and tags each with its dimension.
module sbtp_front (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic [23:0]            coordinate_i,
  input  logic                   last_coordinate_i,
  input  logic                   full_i,
  output logic                   push_o,
  output sbtp_pkg::entry_t       entry_o
);
  import sbtp_pkg::*;

  logic [DIM_W-1:0] cur_dim_q, cur_dim_d;

  assign in_stall_o    = full_i;
  assign push_o        = in_valid_i & ~full_i;
  assign entry_o.coord = coordinate_i;
  assign entry_o.last  = last_coordinate_i;
  assign entry_o.dim   = cur_dim_q;

  always_comb begin
    cur_dim_d = cur_dim_q;
    if (push_o) begin
      if (last_coordinate_i) begin
        cur_dim_d = '0;
      end else if (cur_dim_q != DIM_W'(DIMS - 1)) begin
        cur_dim_d = cur_dim_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_dim_q <= '0;
    end else begin
      cur_dim_q <= cur_dim_d;
    end
  end

endmodule

[src/sbtp_queue.sv]
// Two-entry queue between the front end and the back end.
module sbtp_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  sbtp_pkg::entry_t entry_i,
  output logic             full_o,
  output logic             valid_o,
  output sbtp_pkg::entry_t entry_o,
  input  logic             pop_i
);
  import sbtp_pkg::*;

  entry_t     slot_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;

  assign full_o  = (cnt_q == 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign entry_o = slot_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_q] <= entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) wr_q <= ~wr_q;
      if (pop_i)  rd_q <= ~rd_q;
      cnt_q <= cnt_q + {1'b0, push_i} - {1'b0, pop_i};
    end
  end

endmodule

[src/sbtp_back.sv]
// Back end: division, sine evaluation, scale factors and product emission.
module sbtp_back (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  q_valid_i,
  input  sbtp_pkg::entry_t      q_entry_i,
  output logic                  q_pop_o,
  input  sbtp_pkg::widths_t     widths_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic signed [31:0]    basis_value_o,
  output logic [5:0]            basis_index_o,
  output logic                  last_value_o,
  output logic                  saturated_o
);
  import sbtp_pkg::*;

  localparam logic [4:0] S_IDLE = 5'd0;
  localparam logic [4:0] S_DIV  = 5'd1;
  localparam logic [4:0] S_SQRT = 5'd2;
  localparam logic [4:0] S_S0   = 5'd3;
  localparam logic [4:0] S_S1   = 5'd4;
  localparam logic [4:0] S_S2   = 5'd5;
  localparam logic [4:0] S_S3   = 5'd6;
  localparam logic [4:0] S_S4   = 5'd7;
  localparam logic [4:0] S_S5   = 5'd8;
  localparam logic [4:0] S_S6   = 5'd9;
  localparam logic [4:0] S_ERD  = 5'd10;
  localparam logic [4:0] S_EPRD = 5'd11;
  localparam logic [4:0] S_EACC = 5'd12;
  localparam logic [4:0] S_ERND = 5'd13;
  localparam logic [4:0] S_GLO  = 5'd14;
  localparam logic [4:0] S_GHI  = 5'd15;
  localparam logic [4:0] S_GSUM = 5'd16;
  localparam logic [4:0] S_EOUT = 5'd17;

  localparam logic [38:0] CLAMP_MAG = 39'h40_0000_0000;

  // Control state.
  logic [4:0]       state_q, state_d;
  logic [5:0]       cnt_q, cnt_d;
  logic             gmode_q, gmode_d;
  logic [DIM_W-1:0] dd_q, dd_d;
  logic [J_W-1:0]   j_q, j_d;
  logic [5:0]       idx_q, idx_d;
  logic [J_W-1:0]   jd_q [DIMS];
  logic [J_W-1:0]   jd_d [DIMS];
  logic             out_valid_q, out_valid_d;

  // Data path.
  logic [DIM_W-1:0] dim_q, dim_d;
  logic             last_q, last_d;
  logic             nneg_q, nneg_d;
  logic [48:0]      div_n_q, div_n_d;
  logic [19:0]      div_r_q, div_r_d;
  logic [48:0]      div_o_q, div_o_d;
  logic [19:0]      div_l_q, div_l_d;
  logic [49:0]      sq_v_q, sq_v_d, sq_r_q, sq_r_d, sq_b_q, sq_b_d;
  logic [25:0]      u_q, u_d, qph_q, qph_d;
  logic [30:0]      w_q, w_d;
  logic [61:0]      p_q, t_q, t_d;
  logic [38:0]      a_q, a_d;
  logic             neg_q, neg_d;
  logic [24:0]      g_q [DIMS];
  logic [24:0]      g_d [DIMS];
  logic signed [31:0] val_q, val_d;
  logic [5:0]       oidx_q, oidx_d;
  logic             olast_q, olast_d, osat_q, osat_d;

  // Shared multiplier.
  logic [30:0] mul_a, mul_b;
  logic [61:0] prod;
  assign prod = 62'(mul_a) * 62'(mul_b);

  // Sine store.
  logic                ram_we;
  logic [SINE_AW-1:0]  ram_waddr, ram_raddr;
  logic [SINE_W-1:0]   ram_wdata, ram_rdata;

  sbtp_ram #(.WIDTH(SINE_W), .DEPTH(SINE_DEPTH)) u_sines (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Divider step.
  logic [20:0] div_sh;
  logic        div_ge;
  logic [19:0] div_rn;
  logic [48:0] div_on;
  assign div_sh = {div_r_q, div_n_q[48]};
  assign div_ge = div_sh >= {1'b0, div_l_q};
  assign div_rn = div_ge ? 20'(div_sh - {1'b0, div_l_q}) : div_sh[19:0];
  assign div_on = {div_o_q[47:0], div_ge};

  // Square root step.
  logic [49:0] sq_t;
  logic        sq_ge;
  logic [49:0] sq_rn;
  assign sq_t  = sq_r_q + sq_b_q;
  assign sq_ge = sq_v_q >= sq_t;
  assign sq_rn = sq_ge ? ((sq_r_q >> 1) + sq_b_q) : (sq_r_q >> 1);

  // Phase to folded argument.
  logic [24:0] z;
  logic [30:0] z30;
  assign z   = u_q[24] ? (25'h100_0000 - {1'b0, u_q[23:0]}) : {1'b0, u_q[23:0]};
  assign z30 = {z, 6'b0};

  logic [30:0] w_new, horner;
  assign w_new = p_q[60:30];

  // Sine rounding.
  logic [32:0] s_rnd;
  logic [18:0] s_mag19;
  logic [16:0] s_mag;
  assign s_rnd   = {1'b0, p_q[61:30]} + 33'd8192;
  assign s_mag19 = s_rnd[32:14];
  assign s_mag   = (s_mag19 > 19'd65536) ? 17'd65536 : s_mag19[16:0];

  // Coordinate front arithmetic.
  logic [HW_W-1:0] l_in;
  logic [24:0]     n_sum, n_abs;
  assign l_in  = widths_i[CFG_IDX_W'(q_entry_i.dim)];
  assign n_sum = {q_entry_i.coord[23], q_entry_i.coord} + {5'b0, l_in};
  assign n_abs = n_sum[24] ? (~n_sum + 25'd1) : n_sum;

  // Emission helpers.
  logic [16:0] e_mag;
  logic        e_sgn;
  logic [17:0] e_neg;
  assign e_sgn = ram_rdata[17];
  assign e_neg = ~ram_rdata + 18'd1;
  assign e_mag = e_sgn ? e_neg[16:0] : ram_rdata[16:0];

  logic [62:0] acc_rnd;
  assign acc_rnd = {1'b0, p_q} + 63'd32768;

  logic [63:0] g_full, g_rnd;
  assign g_full = {2'b0, t_q} + ({2'b0, p_q} << 20);
  assign g_rnd  = (g_full + 64'd32768) >> 16;

  logic [38:0] lim;
  logic        lim_over;
  assign lim      = neg_q ? 39'h00_8000_0000 : 39'h00_7FFF_FFFF;
  assign lim_over = a_q > lim;

  logic load_out;
  assign load_out = (state_q == S_EOUT) & (~out_valid_q | ~out_stall_i);

  logic dd_last;
  assign dd_last = (dd_q == DIM_W'(DIMS - 1));

  always_comb begin
    logic        carry;
    logic [38:0] mag;
    state_d = state_q;  cnt_d = cnt_q;   gmode_d = gmode_q; dd_d = dd_q;
    j_d = j_q;          idx_d = idx_q;   jd_d = jd_q;       dim_d = dim_q;
    last_d = last_q;    nneg_d = nneg_q; div_n_d = div_n_q; div_r_d = div_r_q;
    div_o_d = div_o_q;  div_l_d = div_l_q;
    sq_v_d = sq_v_q;    sq_r_d = sq_r_q; sq_b_d = sq_b_q;
    u_d = u_q;          qph_d = qph_q;   w_d = w_q;         t_d = t_q;
    a_d = a_q;          neg_d = neg_q;   g_d = g_q;
    val_d = val_q;      oidx_d = oidx_q; olast_d = olast_q; osat_d = osat_q;
    mul_a = '0;         mul_b = '0;
    ram_we = 1'b0;
    ram_waddr = SINE_AW'(int'(dim_q) * BASIS_PER_DIM + int'(j_q));
    ram_raddr = SINE_AW'(int'(dd_q) * BASIS_PER_DIM + int'(jd_q[dd_q]));
    ram_wdata = u_q[25] ? 18'(~{1'b0, s_mag} + 18'd1) : {1'b0, s_mag};
    horner = '0;
    mag = '0;
    carry = 1'b0;
    q_pop_o = 1'b0;
    out_valid_d = out_valid_q & out_stall_i;

    case (state_q)
      S_IDLE: begin
        if (q_valid_i) begin
          q_pop_o = 1'b1;
          dim_d   = q_entry_i.dim;
          last_d  = q_entry_i.last;
          nneg_d  = n_sum[24];
          div_n_d = {1'b0, n_abs[23:0], 24'b0};
          div_r_d = '0;
          div_o_d = '0;
          div_l_d = l_in;
          gmode_d = 1'b0;
          cnt_d   = 6'd48;
          state_d = S_DIV;
        end
      end
      S_DIV: begin
        div_n_d = {div_n_q[47:0], 1'b0};
        div_r_d = div_rn;
        div_o_d = div_on;
        cnt_d   = cnt_q - 6'd1;
        if (cnt_q == 6'd0) begin
          if (gmode_q) begin
            sq_v_d  = {1'b0, div_on};
            sq_r_d  = '0;
            sq_b_d  = 50'h1_0000_0000_0000;
            cnt_d   = 6'd24;
            state_d = S_SQRT;
          end else begin
            // Floor division: a negative quotient with a remainder steps down.
            qph_d = nneg_q ? 26'(~div_on[25:0] + 26'd1 - {25'b0, div_rn != 20'd0})
                           : div_on[25:0];
            u_d     = nneg_q ? 26'(~div_on[25:0] + 26'd1 - {25'b0, div_rn != 20'd0})
                             : div_on[25:0];
            j_d     = '0;
            state_d = S_S0;
          end
        end
      end
      S_SQRT: begin
        if (sq_ge) sq_v_d = sq_v_q - sq_t;
        sq_r_d = sq_rn;
        sq_b_d = sq_b_q >> 2;
        cnt_d  = cnt_q - 6'd1;
        if (cnt_q == 6'd0) begin
          g_d[dd_q] = sq_rn[24:0];
          if (dd_last) begin
            dd_d    = '0;
            idx_d   = '0;
            for (int d = 0; d < DIMS; d++) jd_d[d] = '0;
            state_d = S_ERD;
          end else begin
            dd_d    = dd_q + 1'b1;
            div_n_d = 49'h1_0000_0000_0000;
            div_r_d = '0;
            div_o_d = '0;
            div_l_d = widths_i[CFG_IDX_W'(dd_q + 1'b1)];
            cnt_d   = 6'd48;
            state_d = S_DIV;
          end
        end
      end
      S_S0: begin
        mul_a = z30; mul_b = z30;
        state_d = S_S1;
      end
      S_S1: begin
        w_d = w_new;
        mul_a = C9; mul_b = w_new;
        state_d = S_S2;
      end
      S_S2: begin
        horner = C7 - p_q[60:30];
        mul_a = horner; mul_b = w_q;
        state_d = S_S3;
      end
      S_S3: begin
        horner = C5 - p_q[60:30];
        mul_a = horner; mul_b = w_q;
        state_d = S_S4;
      end
      S_S4: begin
        horner = C3 - p_q[60:30];
        mul_a = horner; mul_b = w_q;
        state_d = S_S5;
      end
      S_S5: begin
        horner = C1 - p_q[60:30];
        mul_a = horner; mul_b = z30;
        state_d = S_S6;
      end
      S_S6: begin
        ram_we = 1'b1;
        if (j_q == J_W'(BASIS_PER_DIM - 1)) begin
          if (last_q) begin
            dd_d    = '0;
            gmode_d = 1'b1;
            div_n_d = 49'h1_0000_0000_0000;
            div_r_d = '0;
            div_o_d = '0;
            div_l_d = widths_i[CFG_IDX_W'(0)];
            cnt_d   = 6'd48;
            state_d = S_DIV;
          end else begin
            state_d = S_IDLE;
          end
        end else begin
          j_d     = j_q + 1'b1;
          u_d     = u_q + qph_q;
          state_d = S_S0;
        end
      end
      S_ERD: begin
        state_d = S_EPRD;
      end
      S_EPRD: begin
        neg_d = (dd_q == '0) ? e_sgn : (neg_q ^ e_sgn);
        if (dd_q == '0) begin
          a_d = {8'b0, e_mag, 14'b0};
          if (dd_last) begin
            state_d = S_ERND;
          end else begin
            dd_d    = dd_q + 1'b1;
            state_d = S_ERD;
          end
        end else begin
          mul_a = a_q[30:0]; mul_b = {14'b0, e_mag};
          state_d = S_EACC;
        end
      end
      S_EACC: begin
        a_d = acc_rnd[54:16];
        if (dd_last) begin
          state_d = S_ERND;
        end else begin
          dd_d    = dd_q + 1'b1;
          state_d = S_ERD;
        end
      end
      S_ERND: begin
        a_d     = (a_q + 39'd2) >> 2;
        dd_d    = '0;
        state_d = S_GLO;
      end
      S_GLO: begin
        mul_a = {11'b0, a_q[19:0]}; mul_b = {6'b0, g_q[dd_q]};
        state_d = S_GHI;
      end
      S_GHI: begin
        t_d = p_q;
        mul_a = {12'b0, a_q[38:20]}; mul_b = {6'b0, g_q[dd_q]};
        state_d = S_GSUM;
      end
      S_GSUM: begin
        a_d = (g_rnd > 64'(CLAMP_MAG)) ? CLAMP_MAG : g_rnd[38:0];
        if (dd_last) begin
          state_d = S_EOUT;
        end else begin
          dd_d    = dd_q + 1'b1;
          state_d = S_GLO;
        end
      end
      S_EOUT: begin
        if (load_out) begin
          mag         = lim_over ? lim : a_q;
          val_d       = neg_q ? 32'(~mag + 39'd1) : mag[31:0];
          osat_d      = lim_over;
          oidx_d      = idx_q;
          olast_d     = (idx_q == 6'(TOTAL - 1));
          out_valid_d = 1'b1;
          if (idx_q == 6'(TOTAL - 1)) begin
            state_d = S_IDLE;
          end else begin
            idx_d = idx_q + 6'd1;
            carry = 1'b1;
            for (int d = 0; d < DIMS; d++) begin
              if (carry) begin
                if (jd_q[d] == J_W'(BASIS_PER_DIM - 1)) begin
                  jd_d[d] = '0;
                end else begin
                  jd_d[d] = jd_q[d] + 1'b1;
                  carry   = 1'b0;
                end
              end
            end
            dd_d    = '0;
            state_d = S_ERD;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      gmode_q     <= 1'b0;
      dd_q        <= '0;
      j_q         <= '0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
      for (int d = 0; d < DIMS; d++) jd_q[d] <= '0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      gmode_q     <= gmode_d;
      dd_q        <= dd_d;
      j_q         <= j_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
      jd_q        <= jd_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dim_q   <= dim_d;   last_q  <= last_d;  nneg_q  <= nneg_d;
    div_n_q <= div_n_d; div_r_q <= div_r_d; div_o_q <= div_o_d; div_l_q <= div_l_d;
    sq_v_q  <= sq_v_d;  sq_r_q  <= sq_r_d;  sq_b_q  <= sq_b_d;
    u_q     <= u_d;     qph_q   <= qph_d;   w_q     <= w_d;
    p_q     <= prod;    t_q     <= t_d;     a_q     <= a_d;     neg_q <= neg_d;
    g_q     <= g_d;
    val_q   <= val_d;   oidx_q  <= oidx_d;  olast_q <= olast_d; osat_q <= osat_d;
  end

  assign out_valid_o   = out_valid_q;
  assign basis_value_o = val_q;
  assign basis_index_o = oidx_q;
  assign last_value_o  = olast_q;
  assign saturated_o   = osat_q;

endmodule

[src/sine_basis_tensor_product.sv]
// Top level of the sine basis tensor product block: configuration and wiring.
//
//   channel   direction  handshake                  payload
//   input     in         in_valid_i / in_stall_o    coordinate_i, last_coordinate_i
//   output    out        out_valid_o / out_stall_i  basis_value_o, basis_index_o,
//                                                   last_value_o, saturated_o
//   config    in         cfg_we_i                   cfg_index_i, cfg_data_i
//
// Each coordinate beat is taken from the queue, divided in the bit-serial
// divider and then gets one sine per basis function on the shared multiplier.
// A last coordinate then adds the 1/sqrt(L) scale factors (divider and square
// root) for each dimension and then emits the results, holding while the
// output is stalled.
// Reset is asynchronous and active low; the sine store needs no clearing.
// A two-beat queue lets the input side run ahead of the back end, and the
// output register holds a result under stall while nothing else is lost.
module sine_basis_tensor_product (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic signed [23:0] coordinate_i,
  input  logic               last_coordinate_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [31:0] basis_value_o,
  output logic [5:0]         basis_index_o,
  output logic               last_value_o,
  output logic               saturated_o,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_index_i,
  input  logic [19:0]        cfg_data_i
);
  import sbtp_pkg::*;

  // Half-width registers, one for each dimension slot.
  logic [NREG-1:0][HW_W-1:0] hw_q;
  widths_t                   widths;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NREG; i++) hw_q[i] <= HW_RESET;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_HALF_WIDTH_DIM0: hw_q[0] <= cfg_data_i;
        REG_HALF_WIDTH_DIM1: hw_q[1] <= cfg_data_i;
        REG_HALF_WIDTH_DIM2: hw_q[2] <= cfg_data_i;
        REG_HALF_WIDTH_DIM3: hw_q[3] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // A zero half-width behaves as the smallest step, one LSB.
  always_comb begin
    for (int i = 0; i < NREG; i++) begin
      widths[i] = (hw_q[i] == '0) ? HW_W'(1) : hw_q[i];
    end
  end

  logic   push, full, q_valid, q_pop;
  entry_t f_entry, q_entry;

  sbtp_front u_front (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .coordinate_i      (coordinate_i),
    .last_coordinate_i (last_coordinate_i),
    .full_i            (full),
    .push_o            (push),
    .entry_o           (f_entry)
  );

  sbtp_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (f_entry),
    .full_o  (full),
    .valid_o (q_valid),
    .entry_o (q_entry),
    .pop_i   (q_pop)
  );

  sbtp_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_valid_i     (q_valid),
    .q_entry_i     (q_entry),
    .q_pop_o       (q_pop),
    .widths_i      (widths),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .basis_value_o (basis_value_o),
    .basis_index_o (basis_index_o),
    .last_value_o  (last_value_o),
    .saturated_o   (saturated_o)
  );

endmodule

[dv/tb_sine_basis_tensor_product.sv]
// Self-checking testbench for the sine basis tensor product block.
`timescale 1ns / 100ps

module tb_sine_basis_tensor_product;
  import sbtp_pkg::*;

  localparam int  CLK_PERIOD  = 20;
  localparam int  CYCLE_LIMIT = 2000000;
  localparam int  SETTLE      = 400;
  localparam int  PHASE_ITEMS = 75;

  // One result beat as it appears on the output channel.
  typedef struct {
    logic [31:0] value;
    logic [5:0]  index;
    logic        last;
    logic        sat;
  } basis_beat_t;

  // Scoreboard: keeps its own copy of the half-widths, the stored sines and the
  // dimension pointer, and queues the basis values each accepted beat causes.
  class basis_scoreboard;
    bit [19:0]    widths[NREG];
    int           sines[SINE_DEPTH];
    int unsigned  cur_dim;
    basis_beat_t  pending[$];
    int           errors;

    function new();
      for (int i = 0; i < NREG; i++) widths[i] = HW_RESET;
      foreach (sines[i]) sines[i] = 0;
      cur_dim = 0;
      errors  = 0;
    endfunction

    function void write_reg(int i, bit [19:0] v);
      widths[i] = v;
    endfunction

    // A half-width of zero behaves as the smallest step.
    function bit [63:0] eff_width(int d);
      return (widths[d] == 0) ? 64'd1 : 64'(widths[d]);
    endfunction

    function bit [63:0] int_sqrt(bit [63:0] v);
      bit [63:0] r;
      bit [63:0] b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
        if (v >= r + b) begin
          v = v - (r + b);
          r = (r >> 1) + b;
        end else begin
          r = r >> 1;
        end
        b = b >> 2;
      end
      return r;
    endfunction

    // Sine of a phase in quarter turns (Q2.24), returned in Q1.16.
    function int quarter_sine(bit [63:0] u);
      bit [63:0] k, f, z, z30, w, r, s;
      k   = (u >> 24) & 64'd3;
      f   = u & 64'hFF_FFFF;
      z   = k[0] ? (64'd16777216 - f) : f;
      z30 = z << 6;
      w   = (z30 * z30) >> 30;
      r   = 64'(C9);
      r   = 64'(C7) - ((r * w) >> 30);
      r   = 64'(C5) - ((r * w) >> 30);
      r   = 64'(C3) - ((r * w) >> 30);
      r   = 64'(C1) - ((r * w) >> 30);
      s   = (r * z30) >> 30;
      s   = (s + 64'd8192) >> 14;
      if (s > 64'd65536) s = 64'd65536;
      return (k >= 2) ? -int'(s) : int'(s);
    endfunction

    function void note_input(logic signed [23:0] c, logic l);
      longint      x, lw, num, q;
      bit [63:0]   u, a, m, g, lim;
      int          rest, s;
      bit          neg, sat;
      basis_beat_t b;
      x   = c;
      lw  = longint'(eff_width(cur_dim));
      num = (x + lw) * (64'sd1 <<< 24);
      q   = (num >= 0) ? num / lw : -((-num + lw - 1) / lw);
      for (int j = 0; j < BASIS_PER_DIM; j++) begin
        u = (64'(q) * 64'(j + 1)) & 64'h3FF_FFFF;
        sines[cur_dim * BASIS_PER_DIM + j] = quarter_sine(u);
      end
      if (!l) begin
        if (cur_dim + 1 < DIMS) cur_dim++;
        return;
      end
      cur_dim = 0;
      for (int idx = 0; idx < TOTAL; idx++) begin
        rest = idx;
        neg  = 0;
        sat  = 0;
        a    = 0;
        for (int d = 0; d < DIMS; d++) begin
          s    = sines[d * BASIS_PER_DIM + rest % BASIS_PER_DIM];
          m    = (s < 0) ? 64'(-s) : 64'(s);
          rest = rest / BASIS_PER_DIM;
          if (s < 0) neg = !neg;
          if (d == 0) a = m << 14;
          else a = (a * m + 64'd32768) >> 16;
        end
        a = (a + 64'd2) >> 2;
        for (int d = 0; d < DIMS; d++) begin
          g = int_sqrt((64'd1 << 48) / eff_width(d));
          a = (a * g + 64'd32768) >> 16;
          if (a > 64'd274877906944) a = 64'd274877906944;
        end
        lim = neg ? 64'd2147483648 : 64'd2147483647;
        if (a > lim) begin
          a   = lim;
          sat = 1;
        end
        b.value = neg ? 32'(-a) : 32'(a);
        b.index = 6'(idx);
        b.last  = (idx + 1 == TOTAL);
        b.sat   = sat;
        pending.push_back(b);
      end
    endfunction

    function void check_result(logic [31:0] v, logic [5:0] i, logic l, logic st);
      basis_beat_t e;
      if (pending.size() == 0) begin
        $error("unexpected basis beat: value %0h index %0d", v, i);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (v !== e.value) begin
        $error("basis_value: expected %0h, actual %0h", e.value, v);
        errors++;
      end
      if (i !== e.index) begin
        $error("basis_index: expected %0d, actual %0d", e.index, i);
        errors++;
      end
      if (l !== e.last) begin
        $error("last_value: expected %0b, actual %0b", e.last, l);
        errors++;
      end
      if (st !== e.sat) begin
        $error("saturated: expected %0b, actual %0b", e.sat, st);
        errors++;
      end
    endfunction
  endclass

  logic               clk_i;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_stall_o;
  logic signed [23:0] coordinate_i;
  logic               last_coordinate_i;
  logic               out_valid_o;
  logic               out_stall_i;
  logic signed [31:0] basis_value_o;
  logic [5:0]         basis_index_o;
  logic               last_value_o;
  logic               saturated_o;
  logic               cfg_we_i;
  logic [1:0]         cfg_index_i;
  logic [19:0]        cfg_data_i;

  basis_scoreboard sb = new();

  // Register indexes in the order of the half-width list.
  logic [1:0] reg_ids[NREG] = '{REG_HALF_WIDTH_DIM0, REG_HALF_WIDTH_DIM1,
                                REG_HALF_WIDTH_DIM2, REG_HALF_WIDTH_DIM3};

  int  cycles     = 0;
  int  beats_seen = 0;
  // When calm is set neither side idles, so that stretches run at full rate.
  bit  calm       = 0;

  sine_basis_tensor_product i_dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .coordinate_i      (coordinate_i),
    .last_coordinate_i (last_coordinate_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .basis_value_o     (basis_value_o),
    .basis_index_o     (basis_index_o),
    .last_value_o      (last_value_o),
    .saturated_o       (saturated_o),
    .cfg_we_i          (cfg_we_i),
    .cfg_index_i       (cfg_index_i),
    .cfg_data_i        (cfg_data_i)
  );

  initial begin
    clk_i = 0;
    forever #(CLK_PERIOD / 2) clk_i = ~clk_i;
  end

  // Cycle counter with the run limit; the calm flag changes at the falling
  // edge so that it never races with the processes working on rising edges.
  initial begin
    forever begin
      @(negedge clk_i);
      cycles++;
      if (cycles % 400 == 0) calm = ($urandom_range(0, 3) == 0);
      if (cycles > CYCLE_LIMIT) begin
        $display("tb_sine_basis_tensor_product: FAIL");
        $finish;
      end
    end
  end

  // Mostly short gaps, now and then a long one.
  function automatic int pick_gap();
    int p;
    p = $urandom_range(0, 99);
    if (calm || p < 60) return 0;
    if (p < 95) return $urandom_range(1, 3);
    return $urandom_range(20, 80);
  endfunction

  // Receiver: checks every accepted beat and drives the stall. Once, after a
  // few hundred beats, it holds off for a long stretch so that the block's
  // internal queue fills up and the input side is stalled in turn.
  initial begin
    int  hold;
    bit  pressed;
    hold    = 0;
    pressed = 0;
    out_stall_i = 0;
    forever begin
      @(posedge clk_i);
      if (out_valid_o && !out_stall_i) begin
        sb.check_result(basis_value_o, basis_index_o, last_value_o, saturated_o);
        beats_seen++;
      end
      if (!pressed && beats_seen >= 300) begin
        pressed = 1;
        hold    = 3000;
      end
      if (hold > 0) begin
        hold--;
        out_stall_i <= 1'b1;
      end else begin
        hold = pick_gap();
        out_stall_i <= (hold > 0);
        if (hold > 0) hold--;
      end
    end
  end

  // Offers one coordinate beat and waits until the block takes it. The stall
  // is sampled at the edge itself, before the block's registers move on.
  task automatic send_beat(logic signed [23:0] c, logic l);
    int g;
    in_valid_i        <= 1'b1;
    coordinate_i      <= c;
    last_coordinate_i <= l;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_input(c, l);
    g = pick_gap();
    if (g > 0) begin
      in_valid_i <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
  endtask

  // Waits until every expected beat has come, then lets the block finish any
  // coordinate that causes no output before the registers may change.
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic write_widths(bit [19:0] w0, bit [19:0] w1, bit [19:0] w2, bit [19:0] w3);
    bit [19:0] v[NREG];
    v = '{w0, w1, w2, w3};
    for (int i = 0; i < NREG; i++) begin
      cfg_we_i    <= 1'b1;
      cfg_index_i <= reg_ids[i];
      cfg_data_i  <= v[i];
      @(posedge clk_i);
      sb.write_reg(i, v[i]);
    end
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // A coordinate for dimension d: full range, inside the domain, or on an edge.
  function automatic logic signed [23:0] pick_coord(int d);
    int lw;
    lw = int'(sb.eff_width(d));
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return 24'($urandom);
      4, 5, 6, 7: return 24'(int'($urandom_range(0, 2 * lw)) - lw);
      8:          return $urandom_range(0, 1) ? 24'sh7FFFFF : 24'sh800000;
      default:    return $urandom_range(0, 1) ? 24'(lw) : 24'(-lw);
    endcase
  endfunction

  // Mostly whole points; some carry surplus coordinates, some end early.
  task automatic random_phase(int n_items);
    int count, kind, extra;
    count = 0;
    while (count < n_items) begin
      kind = $urandom_range(0, 9);
      if (kind < 8) begin
        for (int d = 0; d < DIMS; d++) send_beat(pick_coord(d), d == DIMS - 1);
        count += DIMS;
      end else if (kind == 8) begin
        extra = $urandom_range(1, 3);
        for (int d = 0; d < DIMS + extra - 1; d++)
          send_beat(pick_coord(d < DIMS ? d : DIMS - 1), 1'b0);
        send_beat(pick_coord(DIMS - 1), 1'b1);
        count += DIMS + extra;
      end else begin
        send_beat(pick_coord(0), 1'b1);
        count++;
      end
    end
  endtask

  initial begin
    in_valid_i        = 0;
    coordinate_i      = '0;
    last_coordinate_i = 0;
    cfg_we_i          = 0;
    cfg_index_i       = '0;
    cfg_data_i        = '0;
    rst_ni            = 0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part at the reset half-widths. The first point is complete so
    // that no later point reads a sine that was never stored.
    send_beat(24'sd0, 1'b0);
    send_beat(24'sd0, 1'b1);
    send_beat(-24'sd262144, 1'b0);
    send_beat(24'sd262144, 1'b1);
    send_beat(24'sh7FFFFF, 1'b0);
    send_beat(24'sh800000, 1'b1);
    send_beat(24'sd131072, 1'b0);
    send_beat(-24'sd131072, 1'b1);
    // Surplus coordinates overwrite the final dimension.
    send_beat(24'sd65536, 1'b0);
    send_beat(24'sd100000, 1'b0);
    send_beat(-24'sd50000, 1'b1);
    // Early last mark reuses the sines of the dimension left out.
    send_beat(24'sd12345, 1'b1);
    send_beat(24'sh800000, 1'b0);
    send_beat(24'sh800000, 1'b1);
    send_beat(24'sh7FFFFF, 1'b0);
    send_beat(24'sh7FFFFF, 1'b1);
    random_phase(PHASE_ITEMS);

    // Smallest half-widths: large scale factors, saturation.
    wait_idle();
    write_widths(20'd1, 20'd1, 20'd1, 20'd1);
    send_beat(24'sd1, 1'b0);
    send_beat(-24'sd1, 1'b1);
    random_phase(PHASE_ITEMS);

    // Largest half-widths.
    wait_idle();
    write_widths(20'hFFFFF, 20'hFFFFF, 20'hFFFFF, 20'hFFFFF);
    random_phase(PHASE_ITEMS);

    // A zero half-width behaves as one.
    wait_idle();
    write_widths(20'd0, 20'd0, 20'd0, 20'd0);
    random_phase(PHASE_ITEMS);

    wait_idle();
    write_widths(20'd1, 20'hFFFFF, 20'd0, 20'($urandom));
    random_phase(PHASE_ITEMS);

    wait_idle();
    write_widths(20'($urandom_range(1, 20'hFFFFF)), 20'($urandom_range(1, 65536)),
                 20'($urandom), 20'($urandom));
    random_phase(PHASE_ITEMS);

    // Drain and allow a little extra time for stray beats.
    in_valid_i <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (1000) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("tb_sine_basis_tensor_product: PASS");
    end else begin
      $display("tb_sine_basis_tensor_product: FAIL");
    end
    $finish;
  end

endmodule

[sim.f]
src/sbtp_pkg.sv
src/sbtp_ram.sv
src/sbtp_front.sv
src/sbtp_queue.sv
src/sbtp_back.sv
src/sine_basis_tensor_product.sv
dv/tb_sine_basis_tensor_product.sv
